// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/qbv_pkg.sv =====
// ----------------------------------------------------------------------------
// qbv_pkg
// Widths, types and helpers of the shortest-arc quaternion block.
// ----------------------------------------------------------------------------
package qbv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int THR_W     = 15;
	localparam int PROD_W    = 2 * IN_W;
	localparam int CR_W      = PROD_W + 1;
	localparam int RL_W      = PROD_W + 2;
	localparam int MAG_W     = PROD_W;
	localparam int NRM_W     = 30;
	localparam int SQ_W      = 2 * NRM_W;
	localparam int N2_W      = SQ_W + 2;
	localparam int ROOT_W    = N2_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int Q_W       = 16;
	localparam int NUM_W     = NRM_W + FRAC_BITS + 1;
	localparam int DR_W      = ROOT_W + 1;
	localparam int NCOMP     = 4;
	localparam int FQ_DEPTH  = 4;
	localparam int FQ_AW     = $clog2(FQ_DEPTH);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
	localparam logic [Q_W-1:0]   Q_SAT     = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0]   Q_ONE     = Q_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [NCOMP-1:0][MAG_W-1:0] mag;
		logic [NCOMP-1:0]            neg;
		logic                        opp;
	} fq_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fq_stat_t;

	typedef struct packed {
		logic [NCOMP-1:0][NRM_W-1:0] m;
		logic [NCOMP-1:0]            neg;
		logic                        opp;
	} nrm_t;

	function automatic logic [IN_W:0] mag_in(input logic signed [IN_W-1:0] v);
		logic signed [IN_W:0] e;
		e = {v[IN_W-1], v};
		mag_in = e[IN_W] ? $unsigned(-e) : $unsigned(e);
	endfunction

endpackage

// ===== hdl/qbv_front.sv =====
// ----------------------------------------------------------------------------
// qbv_front
// Accept vector pairs, form dot and cross products, classify opposite pairs.
// ----------------------------------------------------------------------------
module qbv_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                vec_valid,
	output logic                                vec_stall,
	input  logic signed [qbv_pkg::IN_W-1:0]     ax,
	input  logic signed [qbv_pkg::IN_W-1:0]     ay,
	input  logic signed [qbv_pkg::IN_W-1:0]     az,
	input  logic signed [qbv_pkg::IN_W-1:0]     bx,
	input  logic signed [qbv_pkg::IN_W-1:0]     by_comp,
	input  logic signed [qbv_pkg::IN_W-1:0]     bz,
	input  logic        [qbv_pkg::THR_W-1:0]    thr,
	input  qbv_pkg::fq_stat_t                   fq_stat,
	output logic                                fq_push,
	output qbv_pkg::fq_entry_t                  fq_din
);

	localparam int PW = qbv_pkg::PROD_W;
	localparam int CW = qbv_pkg::CR_W;
	localparam int RW = qbv_pkg::RL_W;
	localparam int IW = qbv_pkg::IN_W;
	localparam int F  = qbv_pkg::FRAC_BITS;
	localparam logic signed [RW-1:0] ONE_Q2 = RW'(1) << (2 * F);

	logic adv;
	logic v_s1, v_s2, v_s3;

	logic signed [PW-1:0] dp_s1 [3];
	logic signed [PW-1:0] cp_s1 [6];
	logic signed [IW-1:0] ax_s1, ay_s1, az_s1;
	logic                 gt_s1;

	logic signed [RW-1:0] real_s2;
	logic signed [CW-1:0] cr_s2 [3];
	logic signed [IW-1:0] ax_s2, ay_s2, az_s2;
	logic                 gt_s2;

	qbv_pkg::fq_entry_t   e_s3;

	logic signed [RW-1:0] thr_ext;
	logic                 opp;
	logic signed [RW-1:0] c [qbv_pkg::NCOMP];
	qbv_pkg::fq_entry_t   e_nxt;

	assign adv       = !(v_s3 && fq_stat.full);
	assign vec_stall = !adv;
	assign fq_push   = v_s3 && adv;
	assign fq_din    = e_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vec_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s1[0] <= ax * bx;
			dp_s1[1] <= ay * by_comp;
			dp_s1[2] <= az * bz;
			cp_s1[0] <= ay * bz;
			cp_s1[1] <= az * by_comp;
			cp_s1[2] <= az * bx;
			cp_s1[3] <= ax * bz;
			cp_s1[4] <= ax * by_comp;
			cp_s1[5] <= ay * bx;
			ax_s1    <= ax;
			ay_s1    <= ay;
			az_s1    <= az;
			gt_s1    <= qbv_pkg::mag_in(ax) > qbv_pkg::mag_in(az);

			real_s2  <= ONE_Q2 + RW'(dp_s1[0]) + RW'(dp_s1[1]) + RW'(dp_s1[2]);
			cr_s2[0] <= CW'(cp_s1[0]) - CW'(cp_s1[1]);
			cr_s2[1] <= CW'(cp_s1[2]) - CW'(cp_s1[3]);
			cr_s2[2] <= CW'(cp_s1[4]) - CW'(cp_s1[5]);
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			az_s2    <= az_s1;
			gt_s2    <= gt_s1;

			e_s3     <= e_nxt;
		end
	end

	always_comb begin
		logic signed [RW-1:0] nv;
		thr_ext = $signed({{(RW - qbv_pkg::THR_W - F){1'b0}}, thr, {F{1'b0}}});
		opp     = real_s2 < thr_ext;
		if (opp) begin
			if (gt_s2) begin
				c[0] = -RW'(ay_s2);
				c[1] = RW'(ax_s2);
				c[2] = '0;
			end else begin
				c[0] = '0;
				c[1] = -RW'(az_s2);
				c[2] = RW'(ay_s2);
			end
			c[3] = '0;
		end else begin
			c[0] = RW'(cr_s2[0]);
			c[1] = RW'(cr_s2[1]);
			c[2] = RW'(cr_s2[2]);
			c[3] = real_s2;
		end
		e_nxt.opp = opp;
		for (int i = 0; i < qbv_pkg::NCOMP; i++) begin
			nv             = -c[i];
			e_nxt.neg[i]   = c[i][RW-1];
			e_nxt.mag[i]   = c[i][RW-1] ? nv[qbv_pkg::MAG_W-1:0] : c[i][qbv_pkg::MAG_W-1:0];
		end
	end

endmodule

// ===== hdl/qbv_queue.sv =====
// ----------------------------------------------------------------------------
// qbv_queue
// Short queue between the classify front and the normalize back.
// ----------------------------------------------------------------------------
module qbv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qbv_pkg::fq_entry_t din,
	input  logic               pop,
	output qbv_pkg::fq_entry_t dout,
	output qbv_pkg::fq_stat_t  stat
);

	localparam int AW = qbv_pkg::FQ_AW;

	qbv_pkg::fq_entry_t mem [qbv_pkg::FQ_DEPTH];
	logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [AW:0]        cnt_q;

	assign stat.full  = cnt_q == (AW+1)'(qbv_pkg::FQ_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign dout       = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= din;
	end

endmodule

// ===== hdl/qbv_back.sv =====
// ----------------------------------------------------------------------------
// qbv_back
// Normalize: range shift, squares, pipelined square root and divide, round, saturate.
// ----------------------------------------------------------------------------
module qbv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qbv_pkg::fq_stat_t              fq_stat,
	input  qbv_pkg::fq_entry_t             fq_dout,
	output logic                           fq_pop,
	output logic                           quat_valid,
	input  logic                           quat_stall,
	output logic signed [qbv_pkg::Q_W-1:0] qx,
	output logic signed [qbv_pkg::Q_W-1:0] qy,
	output logic signed [qbv_pkg::Q_W-1:0] qz,
	output logic signed [qbv_pkg::Q_W-1:0] qw,
	output logic                           opposite_case,
	output logic                           zero_norm
);

	localparam int NC = qbv_pkg::NCOMP;
	localparam int NW = qbv_pkg::NRM_W;
	localparam int RT = qbv_pkg::ROOT_W;
	localparam int RM = qbv_pkg::REM_W;
	localparam int N2 = qbv_pkg::N2_W;
	localparam int QW = qbv_pkg::Q_W;
	localparam int NM = qbv_pkg::NUM_W;
	localparam int DW = qbv_pkg::DR_W;
	localparam int F  = qbv_pkg::FRAC_BITS;

	logic adv;

	logic                          v_s1, v_s2, v_s3;
	qbv_pkg::nrm_t                 nm_s1, nm_s2, nm_s3;
	logic [NC-1:0][qbv_pkg::SQ_W-1:0] sq_s2;
	logic [N2-1:0]                 n2_s3;

	// square-root stages
	logic                          sv   [RT+1];
	logic [RM-1:0]                 srem [RT+1];
	logic [RT-1:0]                 sroot[RT+1];
	logic [N2-1:0]                 sn2  [RT+1];
	qbv_pkg::nrm_t                 snm  [RT+1];

	// divide stages
	logic                          dv   [QW+1];
	logic [NC-1:0][DW-1:0]         drem [QW+1];
	logic [NC-1:0][NM-1:0]         dnum [QW+1];
	logic [NC-1:0][QW-1:0]         dquo [QW+1];
	logic [RT-1:0]                 dden [QW+1];
	logic                          dzero[QW+1];
	logic [NC-1:0]                 dneg [QW+1];
	logic                          dopp [QW+1];

	logic [1:0]                    shamt;
	qbv_pkg::nrm_t                 nm_nxt;
	logic [NC-1:0][QW-1:0]         res;

	assign adv    = !(quat_valid && quat_stall);
	assign fq_pop = adv && !fq_stat.empty;

	// range shift
	always_comb begin
		logic any31, any30;
		logic [qbv_pkg::MAG_W-1:0] sh;
		any31 = 1'b0;
		any30 = 1'b0;
		for (int i = 0; i < NC; i++) begin
			any31 = any31 | fq_dout.mag[i][NW+1];
			any30 = any30 | fq_dout.mag[i][NW];
		end
		shamt = any31 ? 2'd2 : (any30 ? 2'd1 : 2'd0);
		for (int i = 0; i < NC; i++) begin
			sh          = fq_dout.mag[i] >> shamt;
			nm_nxt.m[i] = sh[NW-1:0];
		end
		nm_nxt.neg = fq_dout.neg;
		nm_nxt.opp = fq_dout.opp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !fq_stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s1 <= nm_nxt;
			for (int i = 0; i < NC; i++) sq_s2[i] <= nm_s1.m[i] * nm_s1.m[i];
			nm_s2 <= nm_s1;
			n2_s3 <= N2'(sq_s2[0]) + N2'(sq_s2[1]) + N2'(sq_s2[2]) + N2'(sq_s2[3]);
			nm_s3 <= nm_s2;
		end
	end

	assign sv[0]    = v_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sn2[0]   = n2_s3;
	assign snm[0]   = nm_s3;

	for (genvar k = 0; k < RT; k++) begin : g_sqrt
		logic [RM-1:0] rs, t;
		assign rs = {srem[k][RM-3:0], sn2[k][N2-1-2*k -: 2]};
		assign t  = RM'({sroot[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else if (adv) sv[k+1] <= sv[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rs >= t) begin
					srem[k+1]  <= rs - t;
					sroot[k+1] <= {sroot[k][RT-2:0], 1'b1};
				end else begin
					srem[k+1]  <= rs;
					sroot[k+1] <= {sroot[k][RT-2:0], 1'b0};
				end
				sn2[k+1] <= sn2[k];
				snm[k+1] <= snm[k];
			end
		end
	end

	// divide setup: numerator with half divisor for round to nearest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv[0] <= 1'b0;
		else if (adv) dv[0] <= sv[RT];
	end

	always_ff @(posedge clk) begin
		logic [NM-1:0] n;
		if (adv) begin
			for (int i = 0; i < NC; i++) begin
				n          = {1'b0, snm[RT].m[i], {F{1'b0}}} + NM'(sroot[RT] >> 1);
				dnum[0][i] <= n;
				drem[0][i] <= DW'(n[NM-1:QW]);
				dquo[0][i] <= '0;
			end
			dden[0]  <= sroot[RT];
			dzero[0] <= sroot[RT] == '0;
			dneg[0]  <= snm[RT].neg;
			dopp[0]  <= snm[RT].opp;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[j+1] <= 1'b0;
			else if (adv) dv[j+1] <= dv[j];
		end

		always_ff @(posedge clk) begin
			logic [DW-1:0] r2;
			if (adv) begin
				for (int i = 0; i < NC; i++) begin
					r2 = {drem[j][i][DW-2:0], dnum[j][i][QW-1-j]};
					if (r2 >= DW'(dden[j])) begin
						drem[j+1][i] <= r2 - DW'(dden[j]);
						dquo[j+1][i] <= {dquo[j][i][QW-2:0], 1'b1};
					end else begin
						drem[j+1][i] <= r2;
						dquo[j+1][i] <= {dquo[j][i][QW-2:0], 1'b0};
					end
				end
				dnum[j+1]  <= dnum[j];
				dden[j+1]  <= dden[j];
				dzero[j+1] <= dzero[j];
				dneg[j+1]  <= dneg[j];
				dopp[j+1]  <= dopp[j];
			end
		end
	end

	// saturate, apply sign, override on zero norm
	always_comb begin
		logic [QW-1:0] m;
		for (int i = 0; i < NC; i++) begin
			m      = dquo[QW][i][QW-1] ? qbv_pkg::Q_SAT : dquo[QW][i];
			res[i] = dneg[QW][i] ? -m : m;
		end
		if (dzero[QW]) begin
			res[0] = '0;
			res[1] = '0;
			res[2] = '0;
			res[3] = qbv_pkg::Q_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quat_valid <= 1'b0;
		else if (adv) quat_valid <= dv[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx            <= res[0];
			qy            <= res[1];
			qz            <= res[2];
			qw            <= res[3];
			opposite_case <= dopp[QW];
			zero_norm     <= dzero[QW];
		end
	end

endmodule

// ===== hdl/quaternion_between_vectors_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_between_vectors_core
// Shortest-arc unit quaternion turning vector A onto vector B, Q1.14.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  vec     | vec_valid / vec_stall   | ax ay az bx by_comp bz
//  quat    | quat_valid / quat_stall | qx qy qz qw opposite_case zero_norm
//  apb     | psel penable pwrite     | paddr pwdata prdata (threshold at 0)
//
// One beat per cycle sustained while quat_stall stays low. Path: front stages,
// 1 queue write, 3 back stages, 31 bit-per-stage root, 1 divide setup,
// 16 divide, 1 output. Queue occupancy and output stalls lengthen the path.
// Reset clears all valids and sets the threshold to 1; no clearing pass.
// A stalled result freezes the back; the front runs on until its 4-entry
// queue fills, then stalls the input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_between_vectors_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           vec_valid,
	output logic                           vec_stall,
	input  logic signed [qbv_pkg::IN_W-1:0] ax,
	input  logic signed [qbv_pkg::IN_W-1:0] ay,
	input  logic signed [qbv_pkg::IN_W-1:0] az,
	input  logic signed [qbv_pkg::IN_W-1:0] bx,
	input  logic signed [qbv_pkg::IN_W-1:0] by_comp,
	input  logic signed [qbv_pkg::IN_W-1:0] bz,
	output logic                           quat_valid,
	input  logic                           quat_stall,
	output logic signed [qbv_pkg::Q_W-1:0] qx,
	output logic signed [qbv_pkg::Q_W-1:0] qy,
	output logic signed [qbv_pkg::Q_W-1:0] qz,
	output logic signed [qbv_pkg::Q_W-1:0] qw,
	output logic                           opposite_case,
	output logic                           zero_norm
);

	logic [qbv_pkg::THR_W-1:0] thr_q;
	logic                      wr_thr;
	qbv_pkg::fq_stat_t         fq_stat;
	qbv_pkg::fq_entry_t        fq_din, fq_dout;
	logic                      fq_push, fq_pop;

	assign pready = 1'b1;
	assign wr_thr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? '0 : 32'(thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= qbv_pkg::THR_RESET;
		else if (wr_thr) thr_q <= pwdata[qbv_pkg::THR_W-1:0];
	end

	qbv_front u_front (
		.clk, .arst_n, .vec_valid, .vec_stall,
		.ax, .ay, .az, .bx, .by_comp, .bz,
		.thr(thr_q), .fq_stat, .fq_push, .fq_din
	);

	qbv_queue u_queue (
		.clk, .arst_n, .push(fq_push), .din(fq_din),
		.pop(fq_pop), .dout(fq_dout), .stat(fq_stat)
	);

	qbv_back u_back (
		.clk, .arst_n, .fq_stat, .fq_dout, .fq_pop,
		.quat_valid, .quat_stall, .qx, .qy, .qz, .qw,
		.opposite_case, .zero_norm
	);

	`AST_IMPLY(a_no_overflow, clk, arst_n, fq_push, !fq_stat.full)
	`AST_IMPLY(a_zero_identity, clk, arst_n, quat_valid && zero_norm, qx == 0 && qy == 0 && qz == 0)
	`AST_IMPLY(a_opp_real, clk, arst_n, quat_valid && opposite_case && !zero_norm, qw == 0)
	`AST_NEXT(a_thr_write, clk, arst_n, wr_thr, thr_q == $past(pwdata[qbv_pkg::THR_W-1:0]))

endmodule

// ===== sim/quaternion_between_vectors_core_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_between_vectors_core_test
// Self-checking bench for the shortest-arc quaternion block: a directed table
// of corner vector pairs, then random phases over several opposite-vector
// thresholds. Each result beat is checked against its table entry or an
// in-bench fixed-point model of the rotation, with random gaps on the input
// and random stalls on the output.
// ----------------------------------------------------------------------------
module quaternion_between_vectors_core_test;

	localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		logic signed [15:0] ax, ay, az, bx, bcy, bz;
	} vec_pair_t;

	typedef struct packed {
		logic signed [15:0] qx, qy, qz, qw;
		logic               opp, zn;
	} quat_t;

	typedef struct packed {
		vec_pair_t                  v;
		logic [qbv_pkg::THR_W-1:0]  thr;
		logic                       known;
		quat_t                      q;
	} corner_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic vec_valid, vec_stall, quat_valid, quat_stall;
	logic signed [15:0] ax, ay, az, bx, by_comp, bz;
	logic signed [15:0] qx, qy, qz, qw;
	logic opposite_case, zero_norm;

	quaternion_between_vectors_core dut (.*);

	quat_t expected_quats[$];
	logic [qbv_pkg::THR_W-1:0] cur_thr;
	int errors;
	int idle_cycles;
	int out_wait = 0;
	bit stall_free;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic quat_t rotate_a_onto_b(vec_pair_t v, logic [qbv_pkg::THR_W-1:0] thr);
		longint a0, a1, a2, b0, b1, b2, dot, re, th;
		longint c[4];
		longint unsigned m[4];
		longint unsigned mx, n2, root, bitv, rem, q;
		int s;
		quat_t r;
		a0 = v.ax; a1 = v.ay; a2 = v.az; b0 = v.bx; b1 = v.bcy; b2 = v.bz;
		dot = a0 * b0 + a1 * b1 + a2 * b2;
		re = (64'sd1 <<< 28) + dot;
		th = longint'(thr) <<< qbv_pkg::FRAC_BITS;
		r.opp = re < th;
		if (r.opp) begin
			if ((a0 < 0 ? -a0 : a0) > (a2 < 0 ? -a2 : a2)) begin
				c[0] = -a1; c[1] = a0; c[2] = 0;
			end else begin
				c[0] = 0; c[1] = -a2; c[2] = a1;
			end
			c[3] = 0;
		end else begin
			c[0] = a1 * b2 - a2 * b1;
			c[1] = a2 * b0 - a0 * b2;
			c[2] = a0 * b1 - a1 * b0;
			c[3] = re;
		end
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			m[i] = c[i] < 0 ? -c[i] : c[i];
			if (m[i] > mx) mx = m[i];
		end
		s = 0;
		while ((mx >> s) >= (64'd1 << 30)) s++;
		n2 = 0;
		for (int i = 0; i < 4; i++) begin
			m[i] = m[i] >> s;
			n2 += m[i] * m[i];
		end
		root = 0;
		rem = n2;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		r.zn = root == 0;
		if (r.zn) begin
			r.qx = 0; r.qy = 0; r.qz = 0; r.qw = 16'sd16384;
			return r;
		end
		for (int i = 0; i < 4; i++) begin
			q = ((m[i] << qbv_pkg::FRAC_BITS) + root / 2) / root;
			if (q > 32767) q = 32767;
			if (c[i] < 0) q = -q;
			case (i)
				0: r.qx = q[15:0];
				1: r.qy = q[15:0];
				2: r.qz = q[15:0];
				default: r.qw = q[15:0];
			endcase
		end
		return r;
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result beat monitor and per-beat output wait
	always @(posedge clk) begin
		quat_t e;
		int nw;
		nw = out_wait;
		if (arst_n && quat_valid && !quat_stall) begin
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %0d %0d %0d %0d",
					$time, qx, qy, qz, qw);
				errors++;
			end else begin
				e = expected_quats.pop_front();
				check_field("qx", e.qx, qx);
				check_field("qy", e.qy, qy);
				check_field("qz", e.qz, qz);
				check_field("qw", e.qw, qw);
				check_field("opposite_case", e.opp, opposite_case);
				check_field("zero_norm", e.zn, zero_norm);
			end
			nw = stall_free ? 0 : $urandom_range(7);
		end else if (quat_valid && nw > 0) begin
			nw--;
		end
		out_wait <= nw;
		quat_stall <= nw != 0;
	end

	always @(posedge clk) begin
		if ((vec_valid && !vec_stall) || (quat_valid && !quat_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic drain();
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [qbv_pkg::THR_W-1:0] thr);
		drain();
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_THRESHOLD;
		pwdata <= 32'(thr);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		cur_thr = thr;
	endtask

	task automatic send_pair(vec_pair_t v, int gap, bit known, quat_t q);
		if (gap > 0) begin
			vec_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		vec_valid <= 1;
		ax <= v.ax; ay <= v.ay; az <= v.az; bx <= v.bx; by_comp <= v.bcy; bz <= v.bz;
		@(posedge clk);
		while (vec_stall) @(posedge clk);
		expected_quats.push_back(known ? q : rotate_a_onto_b(v, cur_thr));
	endtask

	function automatic logic signed [15:0] pick_comp();
		case ($urandom_range(9))
			0, 1, 2: return 16'($urandom);
			3: return 0;
			4: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
		endcase
	endfunction

	function automatic vec_pair_t random_pair();
		vec_pair_t v;
		int kind;
		kind = $urandom_range(9);
		v.ax = pick_comp(); v.ay = pick_comp(); v.az = pick_comp();
		v.bx = pick_comp(); v.bcy = pick_comp(); v.bz = pick_comp();
		if (kind < 4) begin
			// nearly opposite
			v.bx = -v.ax + $signed(16'($urandom_range(64))) - 16'sd32;
			v.bcy = -v.ay + $signed(16'($urandom_range(64))) - 16'sd32;
			v.bz = -v.az + $signed(16'($urandom_range(64))) - 16'sd32;
		end else if (kind == 4) begin
			v.bx = v.ax; v.bcy = v.ay; v.bz = v.az + $signed(16'($urandom_range(8)));
		end
		return v;
	endfunction

	corner_row_t corners[] = '{
		'{'{16384, 0, 0, 16384, 0, 0}, 1, 1, '{0, 0, 0, 16384, 0, 0}},
		'{'{16384, 0, 0, -16384, 0, 0}, 1, 1, '{0, 16384, 0, 0, 1, 0}},
		'{'{0, 0, 16384, 0, 0, -16384}, 1, 1, '{0, -16384, 0, 0, 1, 0}},
		'{'{0, 0, 0, 0, 0, 0}, 1, 1, '{0, 0, 0, 16384, 0, 0}},
		'{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1, 1,
			'{0, 0, 0, 16384, 0, 0}},
		'{'{32767, 32767, 32767, -32768, -32768, -32768}, 1, 0, '0},
		'{'{16384, 0, 0, 0, 16384, 0}, 1, 0, '0},
		'{'{-11585, 11585, 0, 0, -16384, 1}, 1, 0, '0},
		'{'{32767, -32768, 12345, -1, 21, -16384}, 1, 0, '0},
		'{'{16384, 0, 0, -16384, 0, 0}, 0, 1, '{0, 0, 0, 16384, 0, 1}},
		'{'{0, 0, 0, 0, 0, 0}, 0, 1, '{0, 0, 0, 16384, 0, 0}},
		'{'{16384, 0, 0, 0, 16384, 0}, 16384, 0, '0},
		'{'{16384, 0, 0, 16384, 0, 0}, 16384, 1, '{0, 0, 0, 16384, 0, 0}},
		'{'{0, 0, 0, 5, -7, 9}, 32767, 1, '{0, 0, 0, 16384, 1, 1}},
		'{'{0, 16384, 0, 16384, 0, 0}, 32767, 1, '{0, 0, 16384, 0, 1, 0}},
		'{'{16384, 0, 0, 16384, 0, 0}, 32767, 0, '0},
		'{'{-16384, 0, 0, 0, 0, 16384}, 32767, 0, '0}
	};

	logic [qbv_pkg::THR_W-1:0] phase_thr[6];

	initial begin
		int gap;
		errors = 0;
		idle_cycles = 0;
		stall_free = 0;
		cur_thr = qbv_pkg::THR_RESET;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		vec_valid = 0; quat_stall = 0;
		ax = 0; ay = 0; az = 0; bx = 0; by_comp = 0; bz = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (corners[i]) begin
			if (corners[i].thr != cur_thr) begin
				vec_valid <= 0;
				write_threshold(corners[i].thr);
			end
			send_pair(corners[i].v, $urandom_range(2) == 0 ? $urandom_range(7) : 0,
				corners[i].known, corners[i].q);
		end

		phase_thr = '{1, 0, 16384, 32767, 15'($urandom), 1};
		foreach (phase_thr[p]) begin
			vec_valid <= 0;
			write_threshold(phase_thr[p]);
			for (int n = 0; n < 235; n++) begin
				if (n % 60 == 0) stall_free = $urandom_range(3) == 0;
				gap = (n % 60 < 15) ? 0 : $urandom_range(7);
				send_pair(random_pair(), gap, 0, '0);
			end
		end
		vec_valid <= 0;
		stall_free = 0;
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== quaternion_between_vectors_core.f =====
+incdir+hdl
hdl/qbv_pkg.sv
hdl/qbv_front.sv
hdl/qbv_queue.sv
hdl/qbv_back.sv
hdl/quaternion_between_vectors_core.sv
sim/quaternion_between_vectors_core_test.sv
